/* sv/mcc_pkg.sv */
// types and constants shared by the minimum coin change block
`timescale 1ns / 1ps

package mcc_pkg;

  // field widths
  localparam int AmtW   = 10;
  localparam int CoinW  = 10;
  localparam int CountW = 10;
  localparam int NcW    = 3;
  localparam int EntryW = CountW + 1;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int NumCoinRegs = 6;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCoin0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoin5     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoinCount = 3'd6;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef logic [CoinW-1:0] coin_t;

endpackage

/* sv/min_coin_change_core.sv */
// minimum coin change core: table rebuild sequencer, best count memory and result register
`timescale 1ns / 1ps

// Each accepted target_amount rebuilds a table of best coin counts for every
// amount from 1 up to the target, trying each denomination in use once per
// amount through one shared subtract, compare and add unit, with at most one
// memory read per denomination. The denominations in use are coin_count of
// them, limited to MAX_COINS and to six. For each amount S_SCAN tries them
// in turn and issues the table reads, and S_WRITE finishes the last compare
// and writes the entry. Targets of zero, targets above MAX_AMOUNT and the
// case of no denominations go straight to S_DONE. in_ready_o is high only
// while the sequencer is idle. The result sits in an output register, so
// the next query may start while a result still waits to be taken.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i by
// the user only while the block is idle; the block does not enforce this.
// The table needs no clearing: every entry is written before a read.
module min_coin_change_core #(
  parameter int MAX_AMOUNT = 1023,
  parameter int MAX_COINS  = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [mcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mcc_pkg::CfgDataW-1:0]   cfg_data_i,
  // query channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mcc_pkg::AmtW-1:0]       target_amount_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcc_pkg::CountW-1:0]     fewest_coins_o,
  output logic                           found_o
);

  localparam int Depth = MAX_AMOUNT + 1;
  localparam int TabAw = (Depth > 1) ? $clog2(Depth) : 1;
  // denominations usable at once
  localparam int CoinLimit = (MAX_COINS < mcc_pkg::NumCoinRegs) ? MAX_COINS
                                                                 : mcc_pkg::NumCoinRegs;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  mcc_pkg::coin_t             coin_q [mcc_pkg::NumCoinRegs];
  logic [mcc_pkg::NcW-1:0]    coin_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcc_pkg::NumCoinRegs; i++) begin
        coin_q[i] <= mcc_pkg::CoinW'(1);
      end
      coin_count_q <= mcc_pkg::NcW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i inside {[mcc_pkg::RegCoin0:mcc_pkg::RegCoin5]}) begin
        coin_q[cfg_idx_i] <= cfg_data_i;
      end else if (cfg_idx_i == mcc_pkg::RegCoinCount) begin
        coin_count_q <= cfg_data_i[mcc_pkg::NcW-1:0];
      end
      // indexes beyond the list are dropped
    end
  end

  // denominations in use, saturated
  logic [mcc_pkg::NcW-1:0] n_eff;
  assign n_eff = (32'(coin_count_q) > CoinLimit) ? mcc_pkg::NcW'(CoinLimit) : coin_count_q;

  // ---------------------------------------------------------------------------
  // sequencer and datapath registers
  // ---------------------------------------------------------------------------
  mcc_pkg::state_e state_q, state_d;

  logic [mcc_pkg::AmtW-1:0]   tgt_q, tgt_d;     // target of the query
  logic [mcc_pkg::AmtW-1:0]   amt_q, amt_d;     // amount being built
  logic [mcc_pkg::NcW-1:0]    n_q, n_d;         // coins in use for this query
  logic [mcc_pkg::NcW-1:0]    k_q, k_d;         // coin being tried
  logic                       pend_q, pend_d;   // a candidate arrives this cycle
  logic                       zero_q, zero_d;   // candidate comes from amount zero
  logic                       have_q, have_d;   // a best count exists for amt_q
  logic [mcc_pkg::CountW-1:0] best_q, best_d;
  logic [mcc_pkg::CountW-1:0] res_count_q, res_count_d;
  logic                       res_found_q, res_found_d;
  logic                       out_valid_q, out_valid_d;
  logic [mcc_pkg::CountW-1:0] out_count_q, out_count_d;
  logic                       out_found_q, out_found_d;

  // best count table
  logic [mcc_pkg::EntryW-1:0] tab_mem [Depth];
  logic [mcc_pkg::EntryW-1:0] rd_data_q;
  logic                       mem_we, mem_re;
  logic [TabAw-1:0]           mem_waddr, mem_raddr;
  logic [mcc_pkg::EntryW-1:0] mem_wdata;

  logic in_fire;
  assign in_ready_o = (state_q == mcc_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  logic last_coin;
  assign last_coin = (k_q == n_q - mcc_pkg::NcW'(1));

  logic res_load;
  assign res_load = (state_q == mcc_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  // shared unit: subtract coin from amount, and merge the arriving candidate
  mcc_pkg::coin_t             coin_sel;
  logic [mcc_pkg::AmtW-1:0]   rd_diff;
  logic                       coin_ok;
  logic                       cand_ok, better, have_m;
  logic [mcc_pkg::CountW-1:0] cand, best_m;

  assign coin_sel = coin_q[k_q];
  assign rd_diff  = amt_q - coin_sel;
  assign coin_ok  = (coin_sel != '0) && (coin_sel <= amt_q);

  assign cand_ok = pend_q && (zero_q || rd_data_q[mcc_pkg::EntryW-1]);
  assign cand    = (zero_q ? '0 : rd_data_q[mcc_pkg::CountW-1:0]) + mcc_pkg::CountW'(1);
  assign better  = cand_ok && (!have_q || cand < best_q);
  assign best_m  = better ? cand : best_q;
  assign have_m  = have_q || cand_ok;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (target_amount_i == '0 || 32'(target_amount_i) > MAX_AMOUNT ||
              n_eff == '0) begin
            state_d = mcc_pkg::S_DONE;
          end else begin
            state_d = mcc_pkg::S_SCAN;
          end
        end
      end
      mcc_pkg::S_SCAN: begin
        if (last_coin) begin
          state_d = mcc_pkg::S_WRITE;
        end
      end
      mcc_pkg::S_WRITE: begin
        if (amt_q == tgt_q) begin
          state_d = mcc_pkg::S_DONE;
        end else begin
          state_d = mcc_pkg::S_SCAN;
        end
      end
      mcc_pkg::S_DONE: begin
        if (res_load) begin
          state_d = mcc_pkg::S_IDLE;
        end
      end
      default: state_d = mcc_pkg::S_IDLE;
    endcase
  end

  // datapath control and next values
  always_comb begin
    tgt_d       = tgt_q;
    amt_d       = amt_q;
    n_d         = n_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    zero_d      = 1'b0;
    have_d      = have_q;
    best_d      = best_q;
    res_count_d = res_count_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_found_d = out_found_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = TabAw'(amt_q);
    mem_raddr   = TabAw'(rd_diff);
    mem_wdata   = {have_m, have_m ? best_m : '0};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mcc_pkg::S_IDLE: begin
        if (in_fire) begin
          tgt_d       = target_amount_i;
          amt_d       = mcc_pkg::AmtW'(1);
          n_d         = n_eff;
          k_d         = '0;
          have_d      = 1'b0;
          best_d      = '0;
          // amount zero needs no coins; the other early cases are unreachable
          res_count_d = '0;
          res_found_d = (target_amount_i == '0);
        end
      end
      mcc_pkg::S_SCAN: begin
        // issue the read for coin k, merge the candidate of coin k-1
        mem_re = coin_ok && (coin_sel != amt_q);
        pend_d = coin_ok;
        zero_d = (coin_sel == amt_q);
        have_d = have_m;
        best_d = best_m;
        k_d    = last_coin ? '0 : k_q + mcc_pkg::NcW'(1);
      end
      mcc_pkg::S_WRITE: begin
        mem_we = 1'b1;
        have_d = 1'b0;
        best_d = '0;
        if (amt_q == tgt_q) begin
          res_count_d = have_m ? best_m : '0;
          res_found_d = have_m;
        end else begin
          amt_d = amt_q + mcc_pkg::AmtW'(1);
        end
      end
      mcc_pkg::S_DONE: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          out_count_d = res_count_q;
          out_found_d = res_found_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcc_pkg::S_IDLE;
      k_q         <= '0;
      pend_q      <= 1'b0;
      zero_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      zero_q      <= zero_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    amt_q       <= amt_d;
    n_q         <= n_d;
    best_q      <= best_d;
    res_count_q <= res_count_d;
    res_found_q <= res_found_d;
    out_count_q <= out_count_d;
    out_found_q <= out_found_d;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tab_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= tab_mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fewest_coins_o = out_count_q;
  assign found_o        = out_found_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an unreachable amount reports a zero count
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> fewest_coins_o == '0)
    else $error("unreachable result with non-zero count");

  // table reads only look at amounts already built
  a_read_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> rd_diff < amt_q && rd_diff != '0)
    else $error("table read at or above the amount being built");

  // a transaction on the query side closes the input until the query is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a query");

  // the amount being built never passes the target
  a_amt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcc_pkg::S_SCAN || state_q == mcc_pkg::S_WRITE |->
      amt_q != '0 && amt_q <= tgt_q)
    else $error("amount out of range during rebuild");

endmodule
